// File: rtl/core/heading_quaternion_from_point_unit_defines.svh
// ----------------------------------------------------------------------------
// Heading quaternion unit: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HEADING_QUATERNION_FROM_POINT_UNIT_DEFINES_SVH
`define HEADING_QUATERNION_FROM_POINT_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HQFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HQFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hqfp_pkg.sv
// ----------------------------------------------------------------------------
// Heading quaternion unit: package
// Widths, constants and types of the heading quaternion datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hqfp_pkg;

    localparam int COORD_W    = 16;            // Q8.8 coordinates
    localparam int DIFF_W     = COORD_W + 1;   // difference never wraps
    localparam int MAG_W      = COORD_W;       // |difference| <= 65535
    localparam int SQ_W       = 2 * MAG_W;     // squared magnitude
    localparam int SUM_W      = SQ_W + 1;      // dx^2 + dy^2

    // Search for Y = floor(2^31 * |dx| / r): largest k with k^2 * s <= 2^62 * dx^2
    localparam int HALF_SH    = 31;
    localparam int SCALE_SH   = 2 * HALF_SH;
    localparam int K_W        = HALF_SH + 1;
    localparam int KS_W       = 64;            // k * s stays below 2^64
    localparam int REM_W      = SQ_W + SCALE_SH;
    localparam int TRIAL_W    = KS_W + K_W + 1;

    // Integer square root of the half-angle term M (0 .. 2^32)
    localparam int M_W        = K_W + 1;
    localparam int ROOT_W     = (M_W + 1) / 2;
    localparam int SREM_W     = M_W;
    localparam int STRIAL_W   = 2 * ROOT_W + 1;

    localparam int Q_W        = 16;            // unsigned Q1.15 outputs
    localparam logic [Q_W-1:0] ONE_Q15 = Q_W'(1) << (Q_W - 1);
    localparam logic [M_W-1:0] M_MID   = M_W'(1) << HALF_SH;

    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = 2 * Q_W;

    localparam int N_LANES    = 2;
    localparam int LANE_Z     = 0;
    localparam int LANE_W     = 1;

    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_X = 1'b0,
        REG_REF_Y = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic neg;      // dx below zero
        logic at_ref;   // target equals reference
    } t_side;

    typedef struct packed {
        logic           at_ref;
        logic [Q_W-1:0] w;
        logic [Q_W-1:0] z;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/heading_quaternion_from_point_unit.sv
// ----------------------------------------------------------------------------
// Heading quaternion from point
// Gives the yaw quaternion (z = sin(a/2), w = cos(a/2), unsigned Q1.15) that
// points from a configured reference point towards a target point.
//
// Usage:
//   Configuration channel (i_cfg_*): index 0 writes ref_x, index 1 writes
//   ref_y (signed Q8.8). Write only while no item is in flight.
//   Slave stream: tdata carries target_x (bits 15:0) and target_y (31:16).
//   Master stream: tdata carries orient_z (15:0) and orient_w (31:16);
//   tuser carries at_reference, set when target equals reference (then
//   w = 1.0 and z = 0).
//   Throughput is one item per clock while the skid register is empty. An item
//   passes three set-up stages, a 32-stage bit-serial search for
//   2^31*|dx|/r (one quotient bit per stage), one combine stage, a 17-stage
//   square root per component and the output register.
//   Reset clears all valid bits and sets both reference registers to zero;
//   ready stays low during reset.
//   A stalled receiver holds the result in the output register; one further
//   item lands in a skid register, then the whole pipeline freezes and
//   o_s_axis_tready drops until the skid register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "heading_quaternion_from_point_unit_defines.svh"

module heading_quaternion_from_point_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hqfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hqfp_pkg::COORD_W-1:0]        i_cfg_data,
    // target stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [hqfp_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,   // target_x, target_y
    // quaternion stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [hqfp_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,   // orient_z, orient_w
    output logic                                o_m_axis_tuser    // at_reference
);

    import hqfp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic                       r_cfg_ready;
    logic signed [COORD_W-1:0]  r_ref_x;
    logic signed [COORD_W-1:0]  r_ref_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_REF_X: r_ref_x <= i_cfg_data;
                    REG_REF_Y: r_ref_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    // ------------------------------------------------------------------
    // Pipeline enable: the pipeline moves while the skid register is empty
    // ------------------------------------------------------------------
    logic r_in_ready;
    logic r_skid_valid;
    logic n_skid_valid;
    logic w_en;

    assign w_en            = r_in_ready;
    assign o_s_axis_tready = r_in_ready;

    // ------------------------------------------------------------------
    // Stage A: differences
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] w_tx;
    logic signed [COORD_W-1:0] w_ty;
    logic signed [DIFF_W-1:0]  w_dx;
    logic signed [DIFF_W-1:0]  w_dy;
    logic                      r_a_valid;
    logic signed [DIFF_W-1:0]  r_a_dx;
    logic signed [DIFF_W-1:0]  r_a_dy;

    assign w_tx = i_s_axis_tdata[COORD_W-1:0];
    assign w_ty = i_s_axis_tdata[IN_DATA_W-1:COORD_W];
    assign w_dx = DIFF_W'(w_tx) - DIFF_W'(r_ref_x);
    assign w_dy = DIFF_W'(w_ty) - DIFF_W'(r_ref_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx <= w_dx;
            r_a_dy <= w_dy;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: magnitudes squared
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] w_dx_abs;
    logic signed [DIFF_W-1:0] w_dy_abs;
    logic [MAG_W-1:0]         w_adx;
    logic [MAG_W-1:0]         w_ady;
    logic                     r_b_valid;
    logic [SQ_W-1:0]          r_b_dx2;
    logic [SQ_W-1:0]          r_b_dy2;
    t_side                    r_b_side;

    assign w_dx_abs = r_a_dx[DIFF_W-1] ? -r_a_dx : r_a_dx;
    assign w_dy_abs = r_a_dy[DIFF_W-1] ? -r_a_dy : r_a_dy;
    assign w_adx    = w_dx_abs[MAG_W-1:0];
    assign w_ady    = w_dy_abs[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_dx2         <= SQ_W'(w_adx) * SQ_W'(w_adx);
            r_b_dy2         <= SQ_W'(w_ady) * SQ_W'(w_ady);
            r_b_side.neg    <= r_a_dx[DIFF_W-1];
            r_b_side.at_ref <= (r_a_dx == '0) && (r_a_dy == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage C and the bit-serial search, one bit of k per stage.
    // Invariant: rem = 2^62*dx^2 - k^2*s, ks = k*s.
    // ------------------------------------------------------------------
    logic              r_kv   [K_W+1];
    logic [REM_W-1:0]  r_rem  [K_W+1];
    logic [KS_W-1:0]   r_ks   [K_W+1];
    logic [K_W-1:0]    r_k    [K_W+1];
    logic [SUM_W-1:0]  r_s    [K_W+1];
    t_side             r_kside[K_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv[0] <= 1'b0;
        end else if (w_en) begin
            r_kv[0] <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0]   <= REM_W'(r_b_dx2) << SCALE_SH;
            r_ks[0]    <= '0;
            r_k[0]     <= '0;
            r_s[0]     <= SUM_W'(r_b_dx2) + SUM_W'(r_b_dy2);
            r_kside[0] <= r_b_side;
        end
    end

    for (genvar g = 0; g < K_W; g++) begin : g_ksearch
        localparam int B = K_W - 1 - g;

        logic [TRIAL_W-1:0] w_trial;
        logic [TRIAL_W:0]   w_diff;
        logic               w_take;

        // (k + 2^B)^2 * s - k^2 * s = 2^(B+1)*ks + 2^(2B)*s
        assign w_trial = (TRIAL_W'(r_ks[g]) << (B + 1)) + (TRIAL_W'(r_s[g]) << (2 * B));
        assign w_diff  = {1'b0, TRIAL_W'(r_rem[g])} - {1'b0, w_trial};
        assign w_take  = ~w_diff[TRIAL_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_kv[g+1] <= 1'b0;
            end else if (w_en) begin
                r_kv[g+1] <= r_kv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[g+1]   <= w_take ? w_diff[REM_W-1:0] : r_rem[g];
                r_ks[g+1]    <= w_take ? r_ks[g] + (KS_W'(r_s[g]) << B) : r_ks[g];
                r_k[g+1]     <= r_k[g] | (K_W'(w_take) << B);
                r_s[g+1]     <= r_s[g];
                r_kside[g+1] <= r_kside[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: half-angle terms. floor(Y) for a positive cosine argument,
    // ceil(Y) for a negative one; Y is whole only when the remainder is zero.
    // ------------------------------------------------------------------
    logic             w_exact;
    logic [M_W-1:0]   w_fy;
    logic [M_W-1:0]   w_cy;
    logic [M_W-1:0]   w_m_hi;
    logic [M_W-1:0]   w_m_lo;
    t_side            w_dside;

    assign w_dside = r_kside[K_W];
    assign w_exact = (r_rem[K_W] == '0);
    assign w_fy    = M_W'(r_k[K_W]);
    assign w_cy    = w_fy + M_W'(!w_exact);
    assign w_m_hi  = M_MID + w_fy;
    assign w_m_lo  = M_MID - w_cy;

    logic              r_qv   [ROOT_W+1];
    logic              r_qref [ROOT_W+1];
    logic [SREM_W-1:0] r_qrem [N_LANES][ROOT_W+1];
    logic [ROOT_W-1:0] r_root [N_LANES][ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
        end else if (w_en) begin
            r_qv[0] <= r_kv[K_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qref[0]         <= w_dside.at_ref;
            r_qrem[LANE_W][0] <= w_dside.neg ? w_m_lo : w_m_hi;
            r_qrem[LANE_Z][0] <= w_dside.neg ? w_m_hi : w_m_lo;
            r_root[LANE_W][0] <= '0;
            r_root[LANE_Z][0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, one root bit per stage in each lane
    // ------------------------------------------------------------------
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[g+1] <= 1'b0;
            end else if (w_en) begin
                r_qv[g+1] <= r_qv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_qref[g+1] <= r_qref[g];
            end
        end

        for (genvar l = 0; l < N_LANES; l++) begin : g_lane
            logic [STRIAL_W-1:0] w_trial;
            logic [STRIAL_W:0]   w_diff;
            logic                w_take;

            assign w_trial = (STRIAL_W'(r_root[l][g]) << (B + 1))
                           + (STRIAL_W'(1) << (2 * B));
            assign w_diff  = {1'b0, STRIAL_W'(r_qrem[l][g])} - {1'b0, w_trial};
            assign w_take  = ~w_diff[STRIAL_W];

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_qrem[l][g+1] <= w_take ? w_diff[SREM_W-1:0] : r_qrem[l][g];
                    r_root[l][g+1] <= r_root[l][g] | (ROOT_W'(w_take) << B);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding: q = floor((isqrt(M) + 1) / 2)
    // ------------------------------------------------------------------
    logic [ROOT_W:0] w_rz1;
    logic [ROOT_W:0] w_rw1;
    t_result         w_result;

    assign w_rz1 = {1'b0, r_root[LANE_Z][ROOT_W]} + (ROOT_W + 1)'(1);
    assign w_rw1 = {1'b0, r_root[LANE_W][ROOT_W]} + (ROOT_W + 1)'(1);

    always_comb begin
        w_result.at_ref = r_qref[ROOT_W];
        if (r_qref[ROOT_W]) begin
            w_result.z = '0;
            w_result.w = ONE_Q15;
        end else begin
            w_result.z = w_rz1[Q_W:1];
            w_result.w = w_rw1[Q_W:1];
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid
    // ------------------------------------------------------------------
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    t_result r_skid;
    t_result n_skid;
    logic    w_take_out;
    logic    w_incoming;

    assign w_take_out = r_out_valid & i_m_axis_tready;
    assign w_incoming = w_en & r_qv[ROOT_W];

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_take_out) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = w_result;
                n_out_valid  = w_incoming;
            end
        end else if (w_incoming) begin
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_in_ready   <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_in_ready   <= ~n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.w, r_out.z};
    assign o_m_axis_tuser  = r_out.at_ref;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HQFP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid item without output item")
    `HQFP_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_axis_tready, !r_skid_valid, "skid item not moved on after output taken")
    `HQFP_ASSERT_NOW(a_q15_range, i_clk, i_rst_n, r_out_valid, (r_out.z <= ONE_Q15) && (r_out.w <= ONE_Q15), "quaternion component above one")
    `HQFP_ASSERT_NOW(a_at_ref_result, i_clk, i_rst_n, r_out_valid && r_out.at_ref, (r_out.z == '0) && (r_out.w == ONE_Q15), "item at reference not identity")

endmodule

`default_nettype wire

// File: test/tb_heading_quaternion_from_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading quaternion from point: testbench
// Streams target points through the unit under several reference settings,
// works out each yaw quaternion in exact integer arithmetic and compares
// every result item, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------

module tb_heading_quaternion_from_point_unit;
    import hqfp_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 60;     // longer than the pipeline latency
    localparam int MAX_REPORTS    = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_reg               i_cfg_index = REG_REF_X;
    logic [COORD_W-1:0]     i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata = '0;     // target_x, target_y
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;          // orient_z, orient_w
    logic                   o_m_axis_tuser;          // at_reference

    // reference registers as the unit should hold them
    logic signed [COORD_W-1:0] ref_x_q = '0;
    logic signed [COORD_W-1:0] ref_y_q = '0;

    t_result pending_quats[$];
    int      mismatch_count = 0;
    bit      tx_idle_en = 1'b0;
    bit      rx_idle_en = 1'b0;
    int      rx_hold_seq = 0;

    heading_quaternion_from_point_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Code q is reached when (2q-1)^2 <= 2^32 * (r + d) / (2r), r = sqrt(s).
    // Rearranged to r * ((2q-1)^2 - 2^31) <= 2^31 * d and squared to stay exact.
    function automatic bit rounds_to_code(input longint q, input longint d,
                                          input longint unsigned s);
        longint          t;
        longint          a;
        bit              dneg;
        longint unsigned ad;
        longint unsigned aa;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        t    = 2 * q - 1;
        a    = t * t - (longint'(1) << 31);
        dneg = d < 0;
        ad   = dneg ? -d : d;
        if (a <= 0 && !dneg) return 1'b1;
        if (a > 0 && dneg) return 1'b0;
        aa  = (a < 0) ? -a : a;
        lhs = 128'(s) * 128'(aa * aa);
        rhs = 128'(ad * ad) << 62;
        return (a > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // 32768 * sqrt((r + d) / (2r)), nearest, ties up
    function automatic logic [Q_W-1:0] half_angle_code(input longint d,
                                                       input longint unsigned s);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (rounds_to_code(mid, d, s)) lo = mid;
            else hi = mid - 1;
        end
        return Q_W'(lo);
    endfunction

    function automatic t_result predict_heading(input logic signed [COORD_W-1:0] tx,
                                                input logic signed [COORD_W-1:0] ty);
        longint          dx;
        longint          dy;
        longint unsigned s;
        t_result         q;
        dx = longint'(tx) - longint'(ref_x_q);
        dy = longint'(ty) - longint'(ref_y_q);
        if (dx == 0 && dy == 0) begin
            q.at_ref = 1'b1;
            q.w      = ONE_Q15;
            q.z      = '0;
        end else begin
            s        = dx * dx + dy * dy;
            q.at_ref = 1'b0;
            q.z      = half_angle_code(-dx, s);
            q.w      = half_angle_code(dx, s);
        end
        return q;
    endfunction

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_target(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        int      gap;
        t_result want;
        gap  = tx_idle_en ? pick_gap() : 0;
        want = predict_heading(tx, ty);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ty, tx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_quats.push_back(want);
    endtask

    // only called with nothing in flight
    task automatic write_refs(input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_REF_X;
        i_cfg_data  <= rx;
        do @(posedge i_clk); while (!o_cfg_ready);
        ref_x_q = rx;
        i_cfg_index <= REG_REF_Y;
        i_cfg_data  <= ry;
        do @(posedge i_clk); while (!o_cfg_ready);
        ref_y_q = ry;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // biased towards the reference and the x axis, where rounding is tight, and the y axis
    task automatic random_target(output logic [COORD_W-1:0] tx, output logic [COORD_W-1:0] ty);
        int ox;
        int oy;
        ox = $urandom_range(0, 8) - 4;
        oy = $urandom_range(0, 8) - 4;
        case ($urandom_range(0, 9))
            0: begin
                tx = ref_x_q;
                ty = ref_y_q;
            end
            1: begin
                tx = COORD_W'(int'(ref_x_q) + ox);
                ty = ref_y_q;
            end
            2: begin
                tx = COORD_W'(int'(ref_x_q) + ox);
                ty = COORD_W'(int'(ref_y_q) + oy);
            end
            3: begin
                tx = COORD_W'($urandom);
                ty = ref_y_q;
            end
            4: begin
                tx = ref_x_q;
                ty = COORD_W'($urandom);
            end
            default: begin
                tx = COORD_W'($urandom);
                ty = COORD_W'($urandom);
            end
        endcase
    endtask

    task automatic test_directed_points();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_refs(16'h0000, 16'h0000);
        send_target(16'h0000, 16'h0000);    // target on the reference
        send_target(16'h0001, 16'h0000);    // straight along +x
        send_target(16'hFFFF, 16'h0000);    // straight along -x
        send_target(16'h0000, 16'h0001);
        send_target(16'h0000, 16'hFFFF);
        send_target(16'h7FFF, 16'h7FFF);
        send_target(16'h8000, 16'h8000);
        send_target(16'h7FFF, 16'h8000);
        send_target(16'h8000, 16'h7FFF);
        send_target(16'h0001, 16'h8000);
        send_target(16'h5555, 16'hAAAA);
        send_target(16'hAAAA, 16'h5555);
    endtask

    task automatic test_reference_extremes();
        settle();
        write_refs(16'h8000, 16'h7FFF);
        send_target(16'h8000, 16'h7FFF);    // target on a non-zero reference
        send_target(16'h7FFF, 16'h8000);    // largest difference both ways
        send_target(16'h7FFF, 16'h7FFF);
        send_target(16'h8000, 16'h8000);
        settle();
        write_refs(16'h7FFF, 16'h8000);
        send_target(16'h8000, 16'h8000);
        send_target(16'h8000, 16'h7FFF);
        send_target(16'h7FFE, 16'h8001);
        send_target(16'h7FFF, 16'h8000);
    endtask

    task automatic test_random_phases();
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        for (int p = 0; p < 5; p++) begin
            settle();
            tx_idle_en = (p != 1) && (p != 3);
            rx_idle_en = (p != 1) && (p != 2);
            case (p)
                0: begin rx = 16'h0000; ry = 16'h0000; end
                1: begin rx = 16'h7FFF; ry = 16'h8000; end
                2: begin rx = 16'h8000; ry = 16'h7FFF; end
                default: begin rx = COORD_W'($urandom); ry = COORD_W'($urandom); end
            endcase
            write_refs(rx, ry);
            repeat (100) begin
                random_target(tx, ty);
                send_target(tx, ty);
            end
        end
    endtask

    // results held back long enough for the pipeline to fill and stall its input
    task automatic test_back_pressure();
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        settle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_refs(COORD_W'($urandom), COORD_W'($urandom));
        rx_hold_seq++;
        repeat (100) begin
            random_target(tx, ty);
            send_target(tx, ty);
        end
    endtask

    task automatic test_drain_pause();
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        settle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (20) begin
            random_target(tx, ty);
            send_target(tx, ty);
        end
        settle();
        repeat (20) begin
            random_target(tx, ty);
            send_target(tx, ty);
        end
    endtask

    always @(posedge i_clk) begin : result_sink
        int stall_left = 0;
        int hold_seen = 0;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_seen != rx_hold_seq) begin
                hold_seen  = rx_hold_seq;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_quaternions
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.z      = o_m_axis_tdata[Q_W-1:0];
            got.w      = o_m_axis_tdata[2*Q_W-1:Q_W];
            got.at_ref = o_m_axis_tuser;
            if (pending_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item: z=%0d w=%0d at_ref=%0b",
                             got.z, got.w, got.at_ref);
            end else begin
                want = pending_quats.pop_front();
                if (got.z !== want.z || got.w !== want.w || got.at_ref !== want.at_ref) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: z exp %0d got %0d, w exp %0d got %0d, at_ref exp %0b got %0b",
                                 want.z, got.z, want.w, got.w, want.at_ref, got.at_ref);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_reference_extremes();
        test_random_phases();
        test_back_pressure();
        test_drain_pause();
        settle();
        if (mismatch_count == 0) begin
            $display("heading_quaternion_from_point_unit test passed");
        end else begin
            $display("heading_quaternion_from_point_unit test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("heading_quaternion_from_point_unit test failed");
        $finish;
    end

endmodule
